// ----- rtl/periodic_grid_index_unit_macros.svh -----
`ifndef PERIODIC_GRID_INDEX_UNIT_MACROS_SVH
`define PERIODIC_GRID_INDEX_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PGIU_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off while in reset.
`define PGIU_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/pgiu_pkg.sv -----
package pgiu_pkg;

  typedef enum logic [1:0] {
    CMD_SPLIT = 2'd0,
    CMD_JOIN  = 2'd1,
    CMD_STEP  = 2'd2,
    CMD_NONE  = 2'd3
  } cmd_t;

  localparam logic [1:0] AXIS_X    = 2'd0;
  localparam logic [1:0] AXIS_Y    = 2'd1;
  localparam logic [1:0] AXIS_Z    = 2'd2;
  localparam logic [1:0] AXIS_NONE = 2'd3;

  localparam logic [2:0] REG_COUNT_X    = 3'd0;
  localparam logic [2:0] REG_COUNT_Y    = 3'd1;
  localparam logic [2:0] REG_COUNT_Z    = 3'd2;
  localparam logic [2:0] REG_PERIODIC_X = 3'd3;
  localparam logic [2:0] REG_PERIODIC_Y = 3'd4;
  localparam logic [2:0] REG_PERIODIC_Z = 3'd5;

  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 5;

endpackage

// ----- rtl/pgiu_if.sv -----
interface pgiu_in_if #(
  parameter int AXIS_BITS = 10,
  parameter int STEP_BITS = 21
) ();
  import pgiu_pkg::*;
  logic                   valid;
  logic                   ready;
  cmd_t                   cmd;
  logic [3*AXIS_BITS-1:0] index_value;
  logic [AXIS_BITS-1:0]   in_x;
  logic [AXIS_BITS-1:0]   in_y;
  logic [AXIS_BITS-1:0]   in_z;
  logic [1:0]             axis;
  logic [STEP_BITS-1:0]   step;

  modport source (output valid, cmd, index_value, in_x, in_y, in_z, axis, step,
                  input ready);
  modport sink (input valid, cmd, index_value, in_x, in_y, in_z, axis, step,
                output ready);
endinterface

interface pgiu_out_if #(
  parameter int AXIS_BITS = 10
) ();
  logic                   valid;
  logic                   ready;
  logic [AXIS_BITS-1:0]   out_x;
  logic [AXIS_BITS-1:0]   out_y;
  logic [AXIS_BITS-1:0]   out_z;
  logic [3*AXIS_BITS-1:0] flat_out;
  logic [AXIS_BITS-1:0]   stepped;
  logic                   out_range_err;

  modport source (output valid, out_x, out_y, out_z, flat_out, stepped, out_range_err,
                  input ready);
  modport sink (input valid, out_x, out_y, out_z, flat_out, stepped, out_range_err,
                output ready);
endinterface

// ----- rtl/pgiu_div_pipe.sv -----
module pgiu_div_pipe #(
  parameter int NB = 30,
  parameter int DB = 11,
  parameter int PW = 8
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [NB-1:0] in_num,
  input  logic [DB-1:0] in_div,
  input  logic [PW-1:0] in_pay,
  output logic          out_vld,
  output logic [NB-1:0] out_quo,
  output logic [DB-1:0] out_rem,
  output logic [PW-1:0] out_pay
);

  // One restoring step per stage; quotient bits replace consumed dividend bits.
  logic          vld_r [NB];
  logic [NB-1:0] num_r [NB];
  logic [DB-1:0] rem_r [NB];
  logic [DB-1:0] div_r [NB];
  logic [PW-1:0] pay_r [NB];

  for (genvar k = 0; k < NB; k++) begin : g_stg
    logic          v_i;
    logic [NB-1:0] n_i;
    logic [NB-1:0] n_nxt;
    logic [DB-1:0] r_i;
    logic [DB-1:0] d_i;
    logic [DB-1:0] rem_nxt;
    logic [PW-1:0] p_i;
    logic [DB:0]   t;
    logic [DB:0]   dif;
    logic          ge;

    if (k == 0) begin : g_first
      assign v_i = in_vld;
      assign n_i = in_num;
      assign r_i = '0;
      assign d_i = in_div;
      assign p_i = in_pay;
    end else begin : g_rest
      assign v_i = vld_r[k-1];
      assign n_i = num_r[k-1];
      assign r_i = rem_r[k-1];
      assign d_i = div_r[k-1];
      assign p_i = pay_r[k-1];
    end

    always_comb begin
      t       = {r_i, n_i[NB-1-k]};
      dif     = t - {1'b0, d_i};
      ge      = (t >= {1'b0, d_i});
      rem_nxt = ge ? dif[DB-1:0] : t[DB-1:0];
      n_nxt   = n_i;
      n_nxt[NB-1-k] = ge;
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_i;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[k] <= n_nxt;
        rem_r[k] <= rem_nxt;
        div_r[k] <= d_i;
        pay_r[k] <= p_i;
      end
    end
  end

  assign out_vld = vld_r[NB-1];
  assign out_quo = num_r[NB-1];
  assign out_rem = rem_r[NB-1];
  assign out_pay = pay_r[NB-1];

endmodule

// ----- rtl/periodic_grid_index_unit.sv -----
// Address unit for a row-major 3D grid (x slowest, z fastest).
// Input channel in_ch carries one command per item: split a flat index into
// x/y/z, join x/y/z into a flat index, or step one coordinate by a signed
// amount with periodic wrap or bounds check. Output channel out_ch returns
// exactly one result item per input item, in order.
// Axis counts and periodic flags sit in an APB register file; write them
// only while no item is in flight.
// Throughput: one item per cycle, sustained while out_ch takes results.
// The path runs through a stage-1 register, two bit-per-stage divider pipelines
// in series and an output register. The first divider is W1 bits wide, where
// W1 = max(3*AXIS_BITS, max(STEP_BITS, AXIS_BITS+1) + 1) (30 at defaults), and
// divides by count_z (or the stepped axis count); the second divides by count_y.
// Reset (synchronous, active low) empties the pipeline and loads counts of 16
// with all axes periodic.
// When out_ch stalls the whole pipeline holds; in_ch.ready drops only while a
// finished result waits at the output and is not being taken.
module periodic_grid_index_unit #(
  parameter int AXIS_BITS = 10,
  parameter int STEP_BITS = 21
) (
  input  logic                         clk,
  input  logic                         rst_n,
  pgiu_in_if.sink                      in_ch,
  pgiu_out_if.source                   out_ch,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [pgiu_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pgiu_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pgiu_pkg::CFG_DATA_W-1:0] prdata,
  output logic                         pready
);
  import pgiu_pkg::*;

`include "periodic_grid_index_unit_macros.svh"

  localparam int A   = AXIS_BITS;
  localparam int S   = STEP_BITS;
  localparam int IW  = 3 * A;
  localparam int CW  = A + 1;
  localparam int MW  = ((S > CW) ? S : CW) + 1;
  localparam int GW  = (IW > S) ? IW : S;
  localparam int W1  = (IW > MW) ? IW : MW;
  localparam int PW1 = 2 * A + 1;
  localparam int FW  = PW1 + CW;
  localparam logic [CW-1:0] CNT_MAX = {1'b1, {A{1'b0}}};

  typedef struct packed {
    cmd_t          cmd;
    logic [IW-1:0] idx;
    logic [MW-1:0] dvd;
    logic [CW-1:0] cnt;
    logic          per;
    logic          neg;
    logic          ige_mag;
    logic          slt;
    logic          oor;
    logic [A-1:0]  dif;
    logic [A-1:0]  z;
    logic [PW1-1:0] p1;
  } s1_t;

  typedef struct packed {
    cmd_t          cmd;
    logic [IW-1:0] flat;
    logic [CW-1:0] cnt;
    logic          per;
    logic          neg;
    logic          ige_mag;
    logic          slt;
    logic          oor;
    logic [A-1:0]  dif;
  } pa_t;

  typedef struct packed {
    pa_t           a;
    logic [CW-1:0] rem_a;
  } pb_t;

  typedef struct packed {
    logic [A-1:0]  out_x;
    logic [A-1:0]  out_y;
    logic [A-1:0]  out_z;
    logic [IW-1:0] flat_out;
    logic [A-1:0]  stepped;
    logic          range_err;
  } res_t;

  function automatic logic [CW-1:0] eff_cnt(input logic [CW-1:0] c);
    logic [CW-1:0] r;
    r = c;
    if (c == '0) r = CW'(1);
    else if (c > CNT_MAX) r = CNT_MAX;
    return r;
  endfunction

  // Configuration registers
  logic [CW-1:0] cnt_x_r, cnt_y_r, cnt_z_r;
  logic          per_x_r, per_y_r, per_z_r;
  logic [2:0]    reg_idx;
  logic          cfg_wr;

  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_x_r <= CW'(16);
      cnt_y_r <= CW'(16);
      cnt_z_r <= CW'(16);
      per_x_r <= 1'b1;
      per_y_r <= 1'b1;
      per_z_r <= 1'b1;
    end else if (cfg_wr) begin
      case (reg_idx)
        REG_COUNT_X:    cnt_x_r <= pwdata[CW-1:0];
        REG_COUNT_Y:    cnt_y_r <= pwdata[CW-1:0];
        REG_COUNT_Z:    cnt_z_r <= pwdata[CW-1:0];
        REG_PERIODIC_X: per_x_r <= pwdata[0];
        REG_PERIODIC_Y: per_y_r <= pwdata[0];
        REG_PERIODIC_Z: per_z_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_COUNT_X:    prdata = CFG_DATA_W'(cnt_x_r);
      REG_COUNT_Y:    prdata = CFG_DATA_W'(cnt_y_r);
      REG_COUNT_Z:    prdata = CFG_DATA_W'(cnt_z_r);
      REG_PERIODIC_X: prdata = CFG_DATA_W'(per_x_r);
      REG_PERIODIC_Y: prdata = CFG_DATA_W'(per_y_r);
      REG_PERIODIC_Z: prdata = CFG_DATA_W'(per_z_r);
      default:        prdata = '0;
    endcase
  end

  logic [CW-1:0] cx, cy, cz;
  assign cx = eff_cnt(cnt_x_r);
  assign cy = eff_cnt(cnt_y_r);
  assign cz = eff_cnt(cnt_z_r);

  // Pipeline advance: everything moves unless a result waits untaken
  logic en;
  logic out_vld_r;
  res_t out_r;

  assign en       = !out_vld_r || out_ch.ready;
  assign in_ch.ready = en;

  // Stage 1: decode, step magnitude, bounds tests, x*cy + y
  s1_t            s1_nxt, s1_r;
  logic           s1_vld_r;
  logic [S-1:0]   stp, mag;
  logic [MW-1:0]  idx_lo, mag_w, sum, ngap, dif_w;

  always_comb begin
    stp    = in_ch.step;
    mag    = stp[S-1] ? (S'(0) - stp) : stp;
    idx_lo = MW'(in_ch.index_value[CW-1:0]);
    mag_w  = MW'(mag);
    sum    = idx_lo + mag_w;
    ngap   = mag_w - idx_lo - MW'(1);
    dif_w  = idx_lo - mag_w;

    s1_nxt.cmd = in_ch.cmd;
    s1_nxt.idx = in_ch.index_value;
    s1_nxt.neg = stp[S-1];
    case (in_ch.axis)
      AXIS_X: begin s1_nxt.cnt = cx; s1_nxt.per = per_x_r; end
      AXIS_Y: begin s1_nxt.cnt = cy; s1_nxt.per = per_y_r; end
      default: begin s1_nxt.cnt = cz; s1_nxt.per = per_z_r; end
    endcase
    s1_nxt.ige_mag = (GW'(in_ch.index_value) >= GW'(mag));
    s1_nxt.slt     = (sum < MW'(s1_nxt.cnt));
    s1_nxt.dif     = dif_w[A-1:0];
    s1_nxt.dvd     = s1_nxt.neg ? (s1_nxt.ige_mag ? '0 : ngap) : sum;
    s1_nxt.z       = in_ch.in_z;
    s1_nxt.p1      = PW1'(in_ch.in_x) * PW1'(cy) + PW1'(in_ch.in_y);
    case (in_ch.cmd)
      CMD_SPLIT: s1_nxt.oor = 1'b0;
      CMD_JOIN:  s1_nxt.oor = (CW'(in_ch.in_x) >= cx) || (CW'(in_ch.in_y) >= cy) ||
                              (CW'(in_ch.in_z) >= cz);
      CMD_STEP:  s1_nxt.oor = (in_ch.axis == AXIS_NONE) ||
                              (in_ch.index_value >= IW'(s1_nxt.cnt));
      default:   s1_nxt.oor = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_r <= s1_nxt;
    end
  end

  // Join product and first divider input
  pa_t            pa_in;
  logic [FW-1:0]  flat_w;
  logic [W1-1:0]  num_a;
  logic [CW-1:0]  div_a;

  always_comb begin
    flat_w        = FW'(s1_r.p1) * FW'(cz) + FW'(s1_r.z);
    pa_in.cmd     = s1_r.cmd;
    pa_in.flat    = flat_w[IW-1:0];
    pa_in.cnt     = s1_r.cnt;
    pa_in.per     = s1_r.per;
    pa_in.neg     = s1_r.neg;
    pa_in.ige_mag = s1_r.ige_mag;
    pa_in.slt     = s1_r.slt;
    pa_in.oor     = s1_r.oor;
    pa_in.dif     = s1_r.dif;
    num_a = (s1_r.cmd == CMD_SPLIT) ? W1'(s1_r.idx) : W1'(s1_r.dvd);
    div_a = (s1_r.cmd == CMD_SPLIT) ? cz : s1_r.cnt;
  end

  logic                  va_vld;
  logic [W1-1:0]         va_quo;
  logic [CW-1:0]         va_rem;
  logic [$bits(pa_t)-1:0] va_pay;

  pgiu_div_pipe #(.NB(W1), .DB(CW), .PW($bits(pa_t))) u_div_a (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (s1_vld_r),
    .in_num  (num_a),
    .in_div  (div_a),
    .in_pay  (pa_in),
    .out_vld (va_vld),
    .out_quo (va_quo),
    .out_rem (va_rem),
    .out_pay (va_pay)
  );

  pb_t pb_in;
  assign pb_in.a     = pa_t'(va_pay);
  assign pb_in.rem_a = va_rem;

  logic                   vb_vld;
  logic [IW-1:0]          vb_quo;
  logic [CW-1:0]          vb_rem;
  logic [$bits(pb_t)-1:0] vb_pay;

  pgiu_div_pipe #(.NB(IW), .DB(CW), .PW($bits(pb_t))) u_div_b (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (va_vld),
    .in_num  (va_quo[IW-1:0]),
    .in_div  (cy),
    .in_pay  (pb_in),
    .out_vld (vb_vld),
    .out_quo (vb_quo),
    .out_rem (vb_rem),
    .out_pay (vb_pay)
  );

  // Result assembly
  pb_t           pb;
  res_t          res_nxt;
  logic [CW-1:0] wrap_neg;

  always_comb begin
    pb       = pb_t'(vb_pay);
    wrap_neg = pb.a.cnt - CW'(1) - pb.rem_a;
    res_nxt  = '0;
    case (pb.a.cmd)
      CMD_SPLIT: begin
        if (vb_quo >= IW'(cx)) begin
          res_nxt.range_err = 1'b1;
        end else begin
          res_nxt.out_x = vb_quo[A-1:0];
          res_nxt.out_y = vb_rem[A-1:0];
          res_nxt.out_z = pb.rem_a[A-1:0];
        end
      end
      CMD_JOIN: begin
        if (pb.a.oor) res_nxt.range_err = 1'b1;
        else res_nxt.flat_out = pb.a.flat;
      end
      CMD_STEP: begin
        if (pb.a.oor) begin
          res_nxt.range_err = 1'b1;
        end else if (!pb.a.neg) begin
          if (pb.a.slt || pb.a.per) res_nxt.stepped = pb.rem_a[A-1:0];
          else res_nxt.range_err = 1'b1;
        end else begin
          if (pb.a.ige_mag) res_nxt.stepped = pb.a.dif;
          else if (pb.a.per) res_nxt.stepped = wrap_neg[A-1:0];
          else res_nxt.range_err = 1'b1;
        end
      end
      default: res_nxt.range_err = 1'b1;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= vb_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_r <= res_nxt;
    end
  end

  assign out_ch.valid         = out_vld_r;
  assign out_ch.out_x         = out_r.out_x;
  assign out_ch.out_y         = out_r.out_y;
  assign out_ch.out_z         = out_r.out_z;
  assign out_ch.flat_out      = out_r.flat_out;
  assign out_ch.stepped       = out_r.stepped;
  assign out_ch.out_range_err = out_r.range_err;

  `PGIU_ASSERT_NOW(a_ready_only_on_stall, !in_ch.ready, out_vld_r && !out_ch.ready, "ready low without output stall")
  `PGIU_ASSERT_NOW(a_oor_zero_fields, out_vld_r && out_r.range_err, (out_r.flat_out == '0) && (out_r.stepped == '0) && (out_r.out_x == '0) && (out_r.out_y == '0) && (out_r.out_z == '0), "out of range result carries data")
  `PGIU_ASSERT_NOW(a_join_excl, out_vld_r && (out_r.flat_out != '0), (out_r.stepped == '0) && (out_r.out_x == '0) && (out_r.out_y == '0) && (out_r.out_z == '0), "join result mixed with other fields")
  `PGIU_ASSERT_NEXT(a_stage1_hold, s1_vld_r && !en, s1_vld_r, "first stage lost an item on stall")

endmodule

// ----- bench/pgiu_tb_if.sv -----
`timescale 1ns / 1ps

// The block's channel interfaces live with the RTL; this file only holds
// the bench's own bookkeeping type for one expected result item.
package pgiu_tb_pkg;
  typedef struct packed {
    logic [9:0]  gx;
    logic [9:0]  gy;
    logic [9:0]  gz;
    logic [29:0] flat;
    logic [9:0]  moved;
    logic        oor;
  } grid_result_t;
endpackage

// ----- bench/testbench.sv -----
`timescale 1ns / 1ps

module testbench;
  import pgiu_pkg::*;
  import pgiu_tb_pkg::*;

  localparam int LIMIT = 400000;
  localparam int DRAIN = 80;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [CFG_ADDR_W-1:0] paddr = '0;
  logic [CFG_DATA_W-1:0] pwdata = '0;
  logic [CFG_DATA_W-1:0] prdata;
  logic pready;

  pgiu_in_if #(.AXIS_BITS(10), .STEP_BITS(21)) in_ch ();
  pgiu_out_if #(.AXIS_BITS(10)) out_ch ();

  periodic_grid_index_unit #(.AXIS_BITS(10), .STEP_BITS(21)) uut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch), .out_ch(out_ch),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  always #6 clk = ~clk;

  // shadow of the register file
  logic [10:0] cnt_reg [3];
  logic        per_reg [3];

  grid_result_t expected_q[$];
  int errors = 0;
  int cycles = 0;
  int sent = 0;
  int rdy_wait = 0;

  initial begin
    in_ch.valid = 1'b0;
    in_ch.cmd = CMD_SPLIT;
    in_ch.index_value = '0;
    in_ch.in_x = '0;
    in_ch.in_y = '0;
    in_ch.in_z = '0;
    in_ch.axis = AXIS_X;
    in_ch.step = '0;
    out_ch.ready = 1'b0;
  end

  task automatic report(input string what, input logic [63:0] got, input logic [63:0] want);
    $display("mismatch %s: got %0d want %0d at %0t", what, got, want, $realtime);
    errors++;
  endtask

  function automatic logic [63:0] eff_count(input logic [10:0] c);
    if (c == 0) return 64'd1;
    if (c > 11'd1024) return 64'd1024;
    return {53'd0, c};
  endfunction

  // Compute the grid address result for one command.
  function automatic grid_result_t grid_predict(input cmd_t cmd, input logic [29:0] idx,
      input logic [9:0] x, input logic [9:0] y, input logic [9:0] z,
      input logic [1:0] ax, input logic [20:0] stp);
    grid_result_t r;
    logic [63:0] cx, cy, cz, cnt, mag, pos;
    logic per, neg;
    r = '0;
    cx = eff_count(cnt_reg[0]);
    cy = eff_count(cnt_reg[1]);
    cz = eff_count(cnt_reg[2]);
    pos = {34'd0, idx};
    case (cmd)
      CMD_SPLIT: begin
        if (pos >= cx * cy * cz) r.oor = 1'b1;
        else begin
          r.gz = 10'(pos % cz);
          r.gy = 10'((pos / cz) % cy);
          r.gx = 10'(pos / (cz * cy));
        end
      end
      CMD_JOIN: begin
        if (x >= cx || y >= cy || z >= cz) r.oor = 1'b1;
        else r.flat = 30'((x * cy + y) * cz + z);
      end
      CMD_STEP: begin
        if (ax == AXIS_NONE) r.oor = 1'b1;
        else begin
          cnt = (ax == AXIS_X) ? cx : (ax == AXIS_Y) ? cy : cz;
          per = per_reg[ax];
          neg = stp[20];
          mag = neg ? (64'd1 << 21) - {43'd0, stp} : {43'd0, stp};
          if (pos >= cnt) r.oor = 1'b1;
          else if (!neg) begin
            if (pos + mag < cnt) r.moved = 10'(pos + mag);
            else if (per) r.moved = 10'((pos + mag) % cnt);
            else r.oor = 1'b1;
          end else begin
            if (pos >= mag) r.moved = 10'(pos - mag);
            else if (per) r.moved = 10'(cnt - 1 - ((mag - pos - 1) % cnt));
            else r.oor = 1'b1;
          end
        end
      end
      default: r.oor = 1'b1;
    endcase
    return r;
  endfunction

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] value);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= CFG_ADDR_W'(idx) << 2; pwdata <= value;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    if (idx <= REG_COUNT_Z) cnt_reg[idx] = value[10:0];
    else per_reg[idx - REG_PERIODIC_X] = value[0];
  endtask

  task automatic set_grid(input logic [10:0] nx, input logic [10:0] ny, input logic [10:0] nz,
      input logic px, input logic py, input logic pz);
    write_reg(REG_COUNT_X, {21'd0, nx});
    write_reg(REG_COUNT_Y, {21'd0, ny});
    write_reg(REG_COUNT_Z, {21'd0, nz});
    write_reg(REG_PERIODIC_X, {31'd0, px});
    write_reg(REG_PERIODIC_Y, {31'd0, py});
    write_reg(REG_PERIODIC_Z, {31'd0, pz});
  endtask

  // Wait for the pipeline to empty before touching registers.
  task automatic drain_results();
    while (expected_q.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  // Drive one item; enqueue its prediction on acceptance.
  task automatic send_cmd(input cmd_t cmd, input logic [29:0] idx, input logic [9:0] x,
      input logic [9:0] y, input logic [9:0] z, input logic [1:0] ax, input logic [20:0] stp,
      input bit has_want = 1'b0, input grid_result_t want = '0);
    grid_result_t p;
    int gap;
    gap = $urandom_range(0, 4);
    if ((sent / 150) % 3 == 2) gap = 0;
    if (gap != 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.cmd <= cmd; in_ch.index_value <= idx;
    in_ch.in_x <= x; in_ch.in_y <= y; in_ch.in_z <= z;
    in_ch.axis <= ax; in_ch.step <= stp;
    p = grid_predict(cmd, idx, x, y, z, ax, stp);
    if (has_want && p != want) report("typed row", 64'(p), 64'(want));
    do @(posedge clk); while (!in_ch.ready);
    expected_q = {expected_q, p};
    sent++;
  endtask

  task automatic end_burst();
    in_ch.valid <= 1'b0;
  endtask

  function automatic grid_result_t res(input logic [9:0] gx, input logic [9:0] gy,
      input logic [9:0] gz, input logic [29:0] flat, input logic [9:0] mv, input logic oor);
    return '{gx: gx, gy: gy, gz: gz, flat: flat, moved: mv, oor: oor};
  endfunction

  typedef struct {
    cmd_t        cmd;
    logic [29:0] idx;
    logic [9:0]  x, y, z;
    logic [1:0]  ax;
    logic [20:0] stp;
    bit          typed;
    grid_result_t want;
  } stim_row_t;

  // random content, mostly in range of the current grid
  task automatic random_item();
    cmd_t c;
    logic [63:0] cx, cy, cz;
    logic [29:0] idx;
    logic [20:0] stp;
    logic [1:0] ax;
    int sel;
    cx = eff_count(cnt_reg[0]); cy = eff_count(cnt_reg[1]); cz = eff_count(cnt_reg[2]);
    sel = $urandom_range(0, 99);
    c = (sel < 4) ? CMD_NONE : cmd_t'($urandom_range(0, 2));
    ax = ($urandom_range(0, 19) == 0) ? AXIS_NONE : 2'($urandom_range(0, 2));
    if (sel % 10 == 0) idx = 30'($urandom);
    else if (c == CMD_SPLIT) idx = 30'($urandom_range(0, 32'(cx * cy * cz + 1)));
    else idx = 30'($urandom_range(0, 32'((ax == AXIS_X ? cx : ax == AXIS_Y ? cy : cz))));
    case ($urandom_range(0, 3))
      0: stp = 21'($urandom);
      1: stp = 21'($signed($urandom_range(0, 8)) - 4);
      default: stp = 21'($signed($urandom_range(0, 4096)) - 2048);
    endcase
    if (sel % 10 == 1)
      send_cmd(c, idx, 10'($urandom), 10'($urandom), 10'($urandom), ax, stp);
    else
      send_cmd(c, idx, 10'($urandom_range(0, 32'(cx))), 10'($urandom_range(0, 32'(cy))),
               10'($urandom_range(0, 32'(cz))), ax, stp);
  endtask

  // output side: per-item stall, compare against oldest expectation
  always @(posedge clk) begin
    grid_result_t w;
    if (rst_n) begin
      if (out_ch.valid && out_ch.ready) begin
        rdy_wait = $urandom_range(0, 4);
        if (expected_q.size() == 0) report("unexpected item", 64'd1, 64'd0);
        else begin
          w = expected_q.pop_front();
          if (out_ch.out_x !== w.gx) report("out_x", out_ch.out_x, w.gx);
          if (out_ch.out_y !== w.gy) report("out_y", out_ch.out_y, w.gy);
          if (out_ch.out_z !== w.gz) report("out_z", out_ch.out_z, w.gz);
          if (out_ch.flat_out !== w.flat) report("flat_out", out_ch.flat_out, w.flat);
          if (out_ch.stepped !== w.moved) report("stepped", out_ch.stepped, w.moved);
          if (out_ch.out_range_err !== w.oor)
            report("out_range_err", out_ch.out_range_err, w.oor);
        end
      end
      if (rdy_wait > 0) begin
        out_ch.ready <= 1'b0;
        rdy_wait--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  stim_row_t rows[$];

  initial begin
    int k;
    cnt_reg = '{11'd16, 11'd16, 11'd16};
    per_reg = '{1'b1, 1'b1, 1'b1};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed rows at reset grid 16x16x16, all periodic
    rows = '{
      '{CMD_SPLIT, 30'd0, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 0)},
      '{CMD_SPLIT, 30'd4095, 0, 0, 0, AXIS_X, 21'd0, 1, res(15, 15, 15, 0, 0, 0)},
      '{CMD_SPLIT, 30'd4096, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_SPLIT, 30'h3fffffff, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_JOIN, 30'd0, 15, 15, 15, AXIS_X, 21'd0, 1, res(0, 0, 0, 4095, 0, 0)},
      '{CMD_JOIN, 30'd0, 16, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_JOIN, 30'd0, 1023, 1023, 1023, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_JOIN, 30'd0, 3, 5, 7, AXIS_X, 21'd0, 0, '0},
      '{CMD_STEP, 30'd15, 0, 0, 0, AXIS_Z, 21'd1, 1, res(0, 0, 0, 0, 0, 0)},
      '{CMD_STEP, 30'd0, 0, 0, 0, AXIS_Y, 21'h1fffff, 1, res(0, 0, 0, 0, 15, 0)},
      '{CMD_STEP, 30'd16, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_STEP, 30'd3, 0, 0, 0, AXIS_NONE, 21'd1, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_STEP, 30'd7, 0, 0, 0, AXIS_X, 21'h0fffff, 0, '0},
      '{CMD_STEP, 30'd7, 0, 0, 0, AXIS_Z, 21'h100000, 0, '0},
      '{CMD_NONE, 30'h3fffffff, 1023, 1023, 1023, AXIS_NONE, 21'h1fffff, 1,
        res(0, 0, 0, 0, 0, 1)}
    };
    foreach (rows[i])
      send_cmd(rows[i].cmd, rows[i].idx, rows[i].x, rows[i].y, rows[i].z, rows[i].ax,
               rows[i].stp, rows[i].typed, rows[i].want);
    end_burst();
    drain_results();

    // bounded axes and the count extremes
    set_grid(11'd1, 11'd0, 11'd2047, 1'b0, 1'b0, 1'b0);
    rows = '{
      '{CMD_SPLIT, 30'd1024, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_SPLIT, 30'd1023, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 1023, 0, 0, 0)},
      '{CMD_STEP, 30'd1023, 0, 0, 0, AXIS_Z, 21'd1, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_STEP, 30'd0, 0, 0, 0, AXIS_Z, 21'h1fffff, 1, res(0, 0, 0, 0, 0, 1)},
      '{CMD_STEP, 30'd0, 0, 0, 0, AXIS_X, 21'd0, 1, res(0, 0, 0, 0, 0, 0)},
      '{CMD_JOIN, 30'd0, 0, 0, 1023, AXIS_X, 21'd0, 1, res(0, 0, 0, 1023, 0, 0)}
    };
    foreach (rows[i])
      send_cmd(rows[i].cmd, rows[i].idx, rows[i].x, rows[i].y, rows[i].z, rows[i].ax,
               rows[i].stp, rows[i].typed, rows[i].want);
    end_burst();
    drain_results();

    for (int phase = 0; phase < 6; phase++) begin
      case (phase)
        0: set_grid(11'd1024, 11'd1024, 11'd1024, 1'b1, 1'b0, 1'b1);
        1: set_grid(11'd7, 11'd3, 11'd5, 1'b0, 1'b1, 1'b0);
        2: set_grid(11'd1, 11'd1, 11'd1, 1'b1, 1'b1, 1'b1);
        default: set_grid(11'($urandom_range(0, 40)), 11'($urandom_range(0, 2047)),
                          11'($urandom_range(1, 300)), 1'($urandom), 1'($urandom), 1'($urandom));
      endcase
      for (k = 0; k < 320; k++) random_item();
      end_burst();
      // hold off the sender until the pipeline has fully emptied
      drain_results();
    end

    if (errors == 0) $display("tb: success");
    else $display("tb: failure");
    $finish;
  end

endmodule
